// File: sv/tbpf_pkg.sv
// Package for the tile background pixel fetch block.
// Holds the transaction structs, register indexes, address constants and helpers.
// Depends on nothing; tbpf_front, tbpf_back and the top level import it.
`default_nettype none

package tbpf_pkg;

  localparam int unsigned SCREEN_COLUMNS = 160;
  localparam int unsigned VRAM_BYTES     = 8192;
  localparam int unsigned ADDR_W         = $clog2(VRAM_BYTES);
  localparam int unsigned CFG_INDEX_W    = 3;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_PIXEL = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_DISPLAY_CONTROL     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCROLL_Y            = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SCROLL_X            = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_Y            = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_X_PLUS_SEVEN = 3'd4;

  localparam int unsigned CTRL_BG_MAP    = 3;
  localparam int unsigned CTRL_TILE_MODE = 4;
  localparam int unsigned CTRL_WIN_EN    = 5;
  localparam int unsigned CTRL_WIN_MAP   = 6;

  localparam logic [7:0] DISPLAY_CONTROL_RESET = 8'd145;

  localparam logic [ADDR_W-1:0] MAP_LOW_OFFSET       = 13'h1800;
  localparam logic [ADDR_W-1:0] MAP_HIGH_OFFSET      = 13'h1C00;
  localparam logic [ADDR_W-1:0] DATA_SIGNED_OFFSET   = 13'h0800;
  localparam logic [ADDR_W-1:0] DATA_UNSIGNED_OFFSET = 13'h0000;

  typedef struct packed {
    logic              action;
    logic [ADDR_W-1:0] vram_address;
    logic [7:0]        write_data;
    logic [7:0]        pixel_x;
    logic [7:0]        screen_line;
  } in_t;

  typedef struct packed {
    logic [1:0] color_index;
    logic [7:0] shade;
    logic       from_window;
  } res_t;

  typedef struct packed {
    logic              is_write;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic              tile_unsigned;
    logic [2:0]        row;
    logic [2:0]        column;
    logic              from_window;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_ISSUE,
    BK_TILE,
    BK_HIGH
  } back_state_t;

  function automatic logic [7:0] shade_of(input logic [1:0] color);
    logic [7:0] s;
    case (color)
      2'd0: s = 8'd255;
      2'd1: s = 8'hCC;
      2'd2: s = 8'h77;
      default: s = 8'd0;
    endcase
    return s;
  endfunction

  // Address of the low plane byte of one row of a tile.
  function automatic logic [ADDR_W-1:0] tile_row_address(input logic [7:0] idx,
                                                         input logic unsigned_mode,
                                                         input logic [2:0] row);
    logic [ADDR_W-1:0] base;
    if (unsigned_mode) begin
      base = DATA_UNSIGNED_OFFSET + {1'b0, idx, 4'b0000};
    end else begin
      base = DATA_SIGNED_OFFSET + {1'b0, ~idx[7], idx[6:0], 4'b0000};
    end
    return base | {9'd0, row, 1'b0};
  endfunction

endpackage

`default_nettype wire

// File: sv/tbpf_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module tbpf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// File: sv/tbpf_fifo.sv
// Small generic first-in first-out queue of registers.
// No dependencies; used between front and back and at the result side.
`default_nettype none

module tbpf_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// File: sv/tbpf_front.sv
// Front part: configuration registers, acceptance and classification of items.
// Turns each write and each on-screen pixel request into a command for the back part; depends on tbpf_pkg.
`default_nettype none

module tbpf_front (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire tbpf_pkg::in_t                      in_item,
  input  wire logic                               push,
  output logic                                    full,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [tbpf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [7:0]                         cfg_data,
  output logic                                    cmd_push,
  output tbpf_pkg::cmd_t                          cmd,
  input  wire logic                               cmd_full
);

  import tbpf_pkg::*;

  logic [7:0] display_control;
  logic [7:0] scroll_y;
  logic [7:0] scroll_x;
  logic [7:0] window_y;
  logic [7:0] window_x_plus_seven;

  logic [8:0] px_plus_seven;
  logic       use_window;
  logic [7:0] xpos;
  logic [7:0] ypos;
  logic       map_sel;
  logic       keep;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      display_control     <= DISPLAY_CONTROL_RESET;
      scroll_y            <= '0;
      scroll_x            <= '0;
      window_y            <= '0;
      window_x_plus_seven <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DISPLAY_CONTROL:     display_control     <= cfg_data;
        REG_SCROLL_Y:            scroll_y            <= cfg_data;
        REG_SCROLL_X:            scroll_x            <= cfg_data;
        REG_WINDOW_Y:            window_y            <= cfg_data;
        REG_WINDOW_X_PLUS_SEVEN: window_x_plus_seven <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    px_plus_seven = {1'b0, in_item.pixel_x} + 9'd7;
    use_window    = display_control[CTRL_WIN_EN]
                    && (in_item.screen_line >= window_y)
                    && (px_plus_seven >= {1'b0, window_x_plus_seven});
    if (use_window) begin
      xpos    = 8'(px_plus_seven - {1'b0, window_x_plus_seven});
      ypos    = in_item.screen_line - window_y;
      map_sel = display_control[CTRL_WIN_MAP];
    end else begin
      xpos    = in_item.pixel_x + scroll_x;
      ypos    = in_item.screen_line + scroll_y;
      map_sel = display_control[CTRL_BG_MAP];
    end

    cmd = '0;
    if (in_item.action == ACT_WRITE) begin
      cmd.is_write = 1'b1;
      cmd.addr     = in_item.vram_address;
      cmd.data     = in_item.write_data;
    end else begin
      cmd.is_write      = 1'b0;
      cmd.addr          = (map_sel ? MAP_HIGH_OFFSET : MAP_LOW_OFFSET)
                          + {3'b000, ypos[7:3], xpos[7:3]};
      cmd.tile_unsigned = display_control[CTRL_TILE_MODE];
      cmd.row           = ypos[2:0];
      cmd.column        = xpos[2:0];
      cmd.from_window   = use_window;
    end

    // Requests for columns off the screen are accepted and dropped here.
    keep     = (in_item.action == ACT_WRITE)
               || ({1'b0, in_item.pixel_x} < 9'(SCREEN_COLUMNS));
    cmd_push = push && !cmd_full && keep;
    full     = cmd_full;
  end

endmodule

`default_nettype wire

// File: sv/tbpf_back.sv
// Back part: sequencer over the video memory port, three reads per pixel.
// Performs writes and produces results; depends on tbpf_pkg.
`default_nettype none

module tbpf_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cmd_valid,
  input  wire tbpf_pkg::cmd_t                cmd,
  output logic                               cmd_pop,
  output logic                               ram_we,
  output logic                               ram_re,
  output logic [tbpf_pkg::ADDR_W-1:0]        ram_addr,
  output logic [7:0]                         ram_wdata,
  input  wire logic [7:0]                    ram_rdata,
  output logic                               res_push,
  output tbpf_pkg::res_t                     res,
  input  wire logic                          res_full
);

  import tbpf_pkg::*;

  back_state_t       state;
  back_state_t       state_next;
  logic              hi_pending;
  logic [ADDR_W-1:0] row_addr;
  logic [7:0]        lo_byte;
  logic              tile_unsigned;
  logic [2:0]        row;
  logic [2:0]        column;
  logic              from_window;
  logic              stall;
  logic [2:0]        bit_sel;
  logic [1:0]        color;
  logic [2:0]        cmd_column_q;
  logic              cmd_window_q;

  assign stall   = hi_pending && res_full;
  assign bit_sel = 3'd7 - column;
  assign color   = {ram_rdata[bit_sel], lo_byte[bit_sel]};

  always_comb begin
    state_next = state;
    unique case (state)
      BK_ISSUE: begin
        if (cmd_valid && !stall && !cmd.is_write) begin
          state_next = BK_TILE;
        end
      end
      BK_TILE: state_next = BK_HIGH;
      BK_HIGH: state_next = BK_ISSUE;
      default: state_next = BK_ISSUE;
    endcase
  end

  always_comb begin
    cmd_pop   = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = cmd.addr;
    ram_wdata = cmd.data;
    res_push  = 1'b0;
    unique case (state)
      BK_ISSUE: begin
        cmd_pop  = cmd_valid && !stall;
        ram_we   = cmd_pop && cmd.is_write;
        ram_re   = cmd_pop && !cmd.is_write;
        res_push = hi_pending && !res_full;
      end
      BK_TILE: begin
        ram_re   = 1'b1;
        ram_addr = tile_row_address(ram_rdata, tile_unsigned, row);
      end
      BK_HIGH: begin
        ram_re   = 1'b1;
        ram_addr = {row_addr[ADDR_W-1:1], 1'b1};
      end
      default: ;
    endcase
    res.color_index = color;
    res.shade       = shade_of(color);
    res.from_window = from_window;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_ISSUE;
      hi_pending <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BK_HIGH) begin
        hi_pending <= 1'b1;
      end else if (res_push) begin
        hi_pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_ISSUE && ram_re) begin
      tile_unsigned <= cmd.tile_unsigned;
      row           <= cmd.row;
    end
    if (state == BK_TILE) begin
      row_addr <= ram_addr;
    end
    if (state == BK_HIGH) begin
      lo_byte <= ram_rdata;
    end
    // The column and layer move on only once the previous result is out.
    if (state == BK_TILE) begin
      column      <= cmd_column_q;
      from_window <= cmd_window_q;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_ISSUE && ram_re) begin
      cmd_column_q <= cmd.column;
      cmd_window_q <= cmd.from_window;
    end
  end

endmodule

`default_nettype wire

// File: sv/tile_background_pixel_fetch.sv
// Top level of the tile background pixel fetch block.
// Instantiates tbpf_front, tbpf_fifo, tbpf_back and tbpf_ram; depends on tbpf_pkg.
//
// Usage: items enter through a queue-like port (push, full, in_item). A write
// item stores one byte in the 8 KiB video memory; a pixel request yields one
// result item, unless its column lies off the screen, in which case it is
// accepted and dropped. Results leave through a queue-like port (result, empty,
// pop): the oldest result is shown while empty is low and is taken by pop.
// Registers are written through cfg_valid, cfg_index and cfg_data; cfg_ready is
// always high. Writes are to be made only while no transaction is in flight;
// the block itself does not enforce this. Each pixel takes three dependent
// reads (map entry, low plane, high plane) on the single video memory port,
// and the back part issues the next command only after a pixel's last read; a
// write uses that port once. A command queue of QUEUE_DEPTH entries parts
// front and back, and a two-entry result queue lets the receiver stall; when it
// does, the back part holds and the front keeps accepting until its queue fills.
// Reset restores the registers (display control 145, others 0) and empties both
// queues; video memory is undefined until written.
`default_nettype none

module tile_background_pixel_fetch #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire tbpf_pkg::in_t                    in_item,
  input  wire logic                             push,
  output logic                                  full,
  output tbpf_pkg::res_t                        result,
  output logic                                  empty,
  input  wire logic                             pop,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [tbpf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [7:0]                       cfg_data
);

  import tbpf_pkg::*;

  cmd_t              front_cmd;
  logic              front_push;
  logic              cmd_full;
  cmd_t              back_cmd;
  logic              cmd_empty;
  logic              cmd_pop;
  logic              ram_we;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_addr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;
  res_t              back_res;
  logic              res_push;
  logic              res_full;

  tbpf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .push      (push),
    .full      (full),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_push  (front_push),
    .cmd       (front_cmd),
    .cmd_full  (cmd_full)
  );

  tbpf_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (front_push),
    .wdata (front_cmd),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (back_cmd),
    .empty (cmd_empty)
  );

  tbpf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!cmd_empty),
    .cmd       (back_cmd),
    .cmd_pop   (cmd_pop),
    .ram_we    (ram_we),
    .ram_re    (ram_re),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata),
    .res_push  (res_push),
    .res       (back_res),
    .res_full  (res_full)
  );

  tbpf_ram #(
    .WIDTH (8),
    .DEPTH (VRAM_BYTES)
  ) u_vram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  tbpf_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (2)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (back_res),
    .full  (res_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule

`default_nettype wire
